### hw/rtl/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared widths, phase codes, state and result types for the UTF-8 decoder
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int unsigned COUNT_WIDTH    = 20;
  localparam int unsigned CAPACITY_WIDTH = 16;
  localparam int unsigned UNIT_WIDTH     = 16;
  localparam int unsigned BYTE_WIDTH     = 8;

  // sequence phase codes
  localparam logic [1:0] PH_LEAD = 2'd0;  // expecting a lead byte
  localparam logic [1:0] PH_LAST = 2'd1;  // expecting final continuation byte
  localparam logic [1:0] PH_MID  = 2'd2;  // expecting middle byte of 3-byte seq

  typedef struct packed {
    logic [CAPACITY_WIDTH-1:0] room_left;
    logic [1:0]                seq_phase;
    logic [UNIT_WIDTH-1:0]     partial_unit;
    logic                      skipping;
    logic [COUNT_WIDTH-1:0]    byte_count;
    logic                      dropped;
  } dec_state_t;

  typedef struct packed {
    logic                   emit;
    logic [UNIT_WIDTH-1:0]  unit_value;
    logic                   unit_write;
    logic                   done_res;
    logic [COUNT_WIDTH-1:0] source_length;
    logic                   truncated;
  } dec_result_t;

  // state at the start of every string
  function automatic dec_state_t restart_state(logic [CAPACITY_WIDTH-1:0] cap);
    dec_state_t s;
    s.room_left    = cap;
    s.seq_phase    = PH_LEAD;
    s.partial_unit = '0;
    s.skipping     = (cap == '0);
    s.byte_count   = '0;
    s.dropped      = 1'b0;
    return s;
  endfunction

endpackage

### hw/rtl/u8dec_step.sv
// ----------------------------------------------------------------------------
// u8dec_step
// Combinational next-state and result logic for one source byte
// ----------------------------------------------------------------------------
module u8dec_step import u8dec_pkg::*; (
  input  dec_state_t                cur_i,
  input  logic [BYTE_WIDTH-1:0]     src_byte_i,
  input  logic [CAPACITY_WIDTH-1:0] cap_i,
  output dec_state_t                nxt_o,
  output dec_result_t               res_o
);

  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   byte_zero;
  logic                   term_now;

  assign count_inc = (cur_i.byte_count == '1) ? cur_i.byte_count
                                              : cur_i.byte_count + COUNT_WIDTH'(1);
  assign byte_zero = (src_byte_i == '0);
  // last slot reached at a lead byte: terminator goes out now
  assign term_now  = !cur_i.skipping && (cur_i.seq_phase == PH_LEAD) &&
                     (cur_i.room_left < CAPACITY_WIDTH'(2));

  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    if (cur_i.skipping || term_now) begin
      nxt_o.skipping = 1'b1;
      if (byte_zero) begin
        res_o.emit          = 1'b1;
        res_o.unit_write    = term_now;
        res_o.done_res      = 1'b1;
        res_o.source_length = cur_i.byte_count;
        res_o.truncated     = cur_i.dropped;
        nxt_o               = restart_state(cap_i);
      end else begin
        nxt_o.byte_count = count_inc;
        nxt_o.dropped    = 1'b1;
        res_o.emit       = term_now;
        res_o.unit_write = term_now;
      end
    end else begin
      case (cur_i.seq_phase)
        PH_LEAD: begin
          nxt_o.room_left = cur_i.room_left - CAPACITY_WIDTH'(1);
          if (byte_zero) begin
            res_o.emit          = 1'b1;
            res_o.unit_write    = 1'b1;
            res_o.done_res      = 1'b1;
            res_o.source_length = cur_i.byte_count;
            nxt_o               = restart_state(cap_i);
          end else begin
            nxt_o.byte_count = count_inc;
            if (!src_byte_i[7]) begin
              res_o.emit       = 1'b1;
              res_o.unit_write = 1'b1;
              res_o.unit_value = {8'h00, src_byte_i};
            end else if (!src_byte_i[5]) begin
              nxt_o.partial_unit = {5'b0, src_byte_i[4:0], 6'b0};
              nxt_o.seq_phase    = PH_LAST;
            end else begin
              nxt_o.partial_unit = {src_byte_i[3:0], 12'b0};
              nxt_o.seq_phase    = PH_MID;
            end
          end
        end
        PH_MID: begin
          nxt_o.byte_count   = count_inc;
          nxt_o.partial_unit = cur_i.partial_unit | {4'b0, src_byte_i[5:0], 6'b0};
          nxt_o.seq_phase    = PH_LAST;
        end
        default: begin
          // final continuation byte (unused code 3 lands here too)
          nxt_o.byte_count   = count_inc;
          res_o.emit         = 1'b1;
          res_o.unit_write   = 1'b1;
          res_o.unit_value   = cur_i.partial_unit | {10'b0, src_byte_i[5:0]};
          nxt_o.partial_unit = '0;
          nxt_o.seq_phase    = PH_LEAD;
        end
      endcase
    end
  end

endmodule

### hw/rtl/u8dec_out_reg.sv
// ----------------------------------------------------------------------------
// u8dec_out_reg
// Result register with valid/ready toward the consumer
// ----------------------------------------------------------------------------
module u8dec_out_reg import u8dec_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  dec_result_t            res_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [UNIT_WIDTH-1:0]  unit_value_o,
  output logic                   unit_write_o,
  output logic                   done_res_o,
  output logic [COUNT_WIDTH-1:0] source_length_o,
  output logic                   truncated_o
);

  logic        valid_q, valid_d;
  dec_result_t data_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign unit_value_o    = data_q.unit_value;
  assign unit_write_o    = data_q.unit_write;
  assign done_res_o      = data_q.done_res;
  assign source_length_o = data_q.source_length;
  assign truncated_o     = data_q.truncated;

endmodule

### hw/rtl/utf8_to_ucs2_bounded_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_ucs2_bounded_decoder
// Bounded UTF-8 to 16-bit code unit decoder with strlcpy-style termination
// ----------------------------------------------------------------------------
//
//   channel   | signals                                  | direction
//   ----------+------------------------------------------+-----------
//   source    | src_valid_i, src_ready_o, src_byte_i     | in
//   result    | out_valid_o, out_ready_i, unit_value_o,  | out
//             | unit_write_o, done_res_o,                |
//             | source_length_o, truncated_o             |
//   config    | cfg_we_i, cfg_wdata_i (dest_capacity)    | in
//
// one source beat per cycle unless the output register stalls; the decoder
// state updates at the accepting edge and any result is loaded into the output
// register at that same edge; throughput is set by the single output register:
// a beat is taken whenever that register is empty or being drained in the same cycle
// reset clears the capacity to zero and puts the decoder at a string start
// a capacity write also restarts the decoder at a string start
//
module utf8_to_ucs2_bounded_decoder import u8dec_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // config
  input  logic                      cfg_we_i,
  input  logic [CAPACITY_WIDTH-1:0] cfg_wdata_i,
  // source bytes
  input  logic                      src_valid_i,
  output logic                      src_ready_o,
  input  logic [BYTE_WIDTH-1:0]     src_byte_i,
  // result beats
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [UNIT_WIDTH-1:0]     unit_value_o,
  output logic                      unit_write_o,
  output logic                      done_res_o,
  output logic [COUNT_WIDTH-1:0]    source_length_o,
  output logic                      truncated_o
);

  logic [CAPACITY_WIDTH-1:0] cap_q;
  dec_state_t                state_q, state_d;
  dec_state_t                step_nxt;
  dec_result_t               step_res;
  logic                      out_free;
  logic                      accept;

  // byte taken whenever the result register can take a beat
  assign src_ready_o = out_free;
  assign accept      = src_valid_i && out_free;

  u8dec_step u_step (
    .cur_i      (state_q),
    .src_byte_i (src_byte_i),
    .cap_i      (cap_q),
    .nxt_o      (step_nxt),
    .res_o      (step_res)
  );

  // config write wins and restarts the string
  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d = restart_state(cfg_wdata_i);
    end else if (accept) begin
      state_d = step_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= '0;
      state_q <= restart_state('0);
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      state_q <= state_d;
    end
  end

  u8dec_out_reg u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (accept && step_res.emit),
    .res_i           (step_res),
    .free_o          (out_free),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .unit_value_o    (unit_value_o),
    .unit_write_o    (unit_write_o),
    .done_res_o      (done_res_o),
    .source_length_o (source_length_o),
    .truncated_o     (truncated_o)
  );

endmodule
